// ===== rtl/pitr_pkg.sv =====
// Shared types, register codes and reset constants for the PI throttle regulator.
`default_nettype none

package pitr_pkg;

  // Default fixed-point format and integrator width
  localparam int FRAC_BITS_DEF = 8;
  localparam int ACC_WIDTH_DEF = 32;

  // Field widths fixed by the interface
  localparam int SPEED_W   = 16;
  localparam int GAIN_W    = 16;
  localparam int ERR_W     = SPEED_W + 1;
  localparam int CFG_IDX_W = 2;

  // Register reset values (Q8.8: 8.113, 0.5, 45.0)
  localparam logic [GAIN_W-1:0]  KP_GAIN_RST      = 16'd2077;
  localparam logic [GAIN_W-1:0]  KI_GAIN_RST      = 16'd128;
  localparam logic [SPEED_W-1:0] THROTTLE_MAX_RST = 16'd11520;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP_GAIN      = 2'd0,
    CFG_KI_GAIN      = 2'd1,
    CFG_THROTTLE_MAX = 2'd2
  } cfg_reg_t;

  // Input transaction payload
  typedef struct packed {
    logic               going_on;
    logic [SPEED_W-1:0] cruise_speed;
    logic [SPEED_W-1:0] vehicle_speed;
  } pitr_in_t;

  // Result transaction payload
  typedef struct packed {
    logic [SPEED_W-1:0] throttle;
    logic               saturated;
  } pitr_out_t;

endpackage

`default_nettype wire

// ===== rtl/pi_throttle_regulator.sv =====
// Each input transaction passes through the input register, then the result register, to result valid.
// Throughput: one transaction per cycle while the output is not stalled; the integrator update, gain products and clamp
// close their feedback loop combinationally between the input and result registers.
// Reset (synchronous rst): pipeline empties, gains and clamp return to defaults,
// integral_sum clears and the integrator starts held.
`default_nettype none

module pi_throttle_regulator
  import pitr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire pitr_in_t             in_data,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output pitr_out_t                 out_data,
  // configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [GAIN_W-1:0]    cfg_data
);

  localparam int PROP_W  = ERR_W + GAIN_W + 1;
  localparam int INTEG_W = ACC_WIDTH + GAIN_W + 1;
  localparam int SUM_W   = ACC_WIDTH + GAIN_W + 2;

  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  // Configuration registers
  logic [GAIN_W-1:0]  kp_gain;
  logic [GAIN_W-1:0]  ki_gain;
  logic [SPEED_W-1:0] throttle_max;

  // Controller state
  logic signed [ACC_WIDTH-1:0] integral_sum;
  logic                        hold_integral;

  // Pipeline registers
  logic     s1_valid;
  pitr_in_t s1_data;

  // Handshake control
  logic out_free;
  logic s1_move;
  logic in_take;

  // Datapath
  logic signed [ERR_W-1:0]     err;
  logic signed [ACC_WIDTH-1:0] integ_base;
  logic                        hold_eff;
  logic signed [ACC_WIDTH:0]   integ_add;
  logic signed [ACC_WIDTH-1:0] integral_sum_next;
  logic signed [PROP_W-1:0]    prop_full;
  logic signed [INTEG_W-1:0]   integ_full;
  logic signed [PROP_W-1:0]    prop_sh;
  logic signed [INTEG_W-1:0]   integ_sh;
  logic signed [SUM_W-1:0]     sum;
  logic signed [SUM_W-1:0]     thr_lim;
  pitr_out_t                   result;

  assign out_free  = !out_valid || !out_stall;
  assign s1_move   = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain      <= KP_GAIN_RST;
      ki_gain      <= KI_GAIN_RST;
      throttle_max <= THROTTLE_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_KP_GAIN:      kp_gain      <= cfg_data;
        CFG_KI_GAIN:      ki_gain      <= cfg_data;
        CFG_THROTTLE_MAX: throttle_max <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Speed error and integrator update; going on clears and holds the integral
  always_comb begin
    err        = $signed({1'b0, s1_data.cruise_speed}) - $signed({1'b0, s1_data.vehicle_speed});
    integ_base = s1_data.going_on ? '0 : integral_sum;
    hold_eff   = s1_data.going_on || hold_integral;
    integ_add  = {integ_base[ACC_WIDTH-1], integ_base}
               + {{(ACC_WIDTH+1-ERR_W){err[ERR_W-1]}}, err};
    if (hold_eff) begin
      integral_sum_next = integ_base;
    end else if (integ_add[ACC_WIDTH] != integ_add[ACC_WIDTH-1]) begin
      integral_sum_next = integ_add[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
    end else begin
      integral_sum_next = integ_add[ACC_WIDTH-1:0];
    end
  end

  // Gain products, floor shift and sum
  always_comb begin
    prop_full  = $signed({1'b0, kp_gain}) * err;
    integ_full = $signed({1'b0, ki_gain}) * integral_sum_next;
    prop_sh    = prop_full >>> FRAC_BITS;
    integ_sh   = integ_full >>> FRAC_BITS;
    sum        = {{(SUM_W-PROP_W){prop_sh[PROP_W-1]}}, prop_sh}
               + {{(SUM_W-INTEG_W){integ_sh[INTEG_W-1]}}, integ_sh};
    thr_lim    = {{(SUM_W-SPEED_W){1'b0}}, throttle_max};
  end

  // Output clamp to 0..throttle_max
  always_comb begin
    if (sum > thr_lim) begin
      result.throttle  = throttle_max;
      result.saturated = 1'b1;
    end else if (sum[SUM_W-1]) begin
      result.throttle  = '0;
      result.saturated = 1'b1;
    end else begin
      result.throttle  = sum[SPEED_W-1:0];
      result.saturated = 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data <= in_data;
    end
  end

  // Controller state advances when an item moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum  <= '0;
      hold_integral <= 1'b1;
    end else if (s1_move) begin
      integral_sum  <= integral_sum_next;
      hold_integral <= result.saturated;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pitr_chk.sv =====
// Port-level checker for the PI throttle regulator, bound to the top level.
`default_nettype none

module pitr_chk
  import pitr_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire pitr_out_t out_data
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // An empty result register never backs up the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with result register empty");

  // An accepted transaction reaches the output if the output is not stalled while it waits in the input register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("result missing after accepted transaction");

endmodule

bind pi_throttle_regulator pitr_chk u_pitr_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
